// ----- rtl/fccr_pkg.sv -----
// ----------------------------------------------------------------------------
// fccr_pkg
// Shared widths, status codes and register indexes of the FAT16 chain reader.
// ----------------------------------------------------------------------------
`default_nettype none

package fccr_pkg;

  localparam int unsigned CLUSTER_W = 16;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    ST_READ    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_ENDED   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_LOOP    = 3'd4,
    ST_BAD     = 3'd5,
    ST_IGNORED = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    CMD_START  = 1'b0,
    CMD_SUPPLY = 1'b1
  } command_t;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPC         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_ENTRIES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EOC_MARK    = 2'd3;

  localparam logic [SIZE_W-1:0]    RST_DATA_START  = 32'd0;
  localparam logic [LEN_W-1:0]     RST_BPC         = 17'd512;
  localparam logic [CNT_W-1:0]     RST_FAT_ENTRIES = 17'd65536;
  localparam logic [CLUSTER_W-1:0] RST_EOC_MARK    = 16'd65528;

  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 16'd2;

endpackage

`default_nettype wire

// ----- rtl/fat16_cluster_chain_reader_core.sv -----
// ----------------------------------------------------------------------------
// fat16_cluster_chain_reader_core
// Walks a FAT16 cluster chain and issues one result per item: a data read request or a status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: tuser is the command (start or supply); a start beat
//   carries the first cluster and file size, a supply beat the FAT entry of
//   the cluster named by the previous result's fat_index.
//   Master stream m_*: one beat per input beat with status (tuser), read
//   offset, read length and the next FAT index (tdata); tlast marks the end
//   of the file or a stopped walk.
//   Config channel cfg_*: always ready; write only while the block is idle.
// Each result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle; the output register is the only stage,
//   and s_tready stays high while that register is empty or being drained.
// A stalled m_tready holds the result and, once the register is full,
//   drops s_tready until the beat leaves.
// Reset: registers return to their reset values, the walk goes idle and
//   the output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module fat16_cluster_chain_reader_core
  import fccr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [15:0] first_cluster, [47:16] file_size, [63:48] next_cluster
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [0] command
  input  wire logic                  s_tuser,
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [31:0] read_offset, [48:32] read_length, [64:49] fat_index, [71:65] zero
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // [2:0] status
  output logic [2:0]                 m_tuser,
  output logic                       m_tlast
);

  logic [SIZE_W-1:0]    data_base;
  logic [LEN_W-1:0]     bpc;
  logic [CNT_W-1:0]     fat_entries;
  logic [CLUSTER_W-1:0] eoc_mark;

  logic [SIZE_W-1:0]    bytes_left;
  logic [SIZE_W-1:0]    bytes_left_next;
  logic [CNT_W-1:0]     steps;
  logic [CNT_W-1:0]     steps_next;
  logic                 walking;
  logic                 walking_next;

  logic                 in_take;
  command_t             cmd;
  logic [CLUSTER_W-1:0] in_first;
  logic [SIZE_W-1:0]    in_size;
  logic [CLUSTER_W-1:0] in_next;

  logic [CLUSTER_W-1:0] clus;
  logic [SIZE_W-1:0]    avail;
  logic                 do_take;
  logic [CLUSTER_W-1:0] clus_rel;
  logic [SIZE_W-1:0]    prod;
  logic [SIZE_W-1:0]    offset;
  logic [LEN_W-1:0]     len;
  logic [SIZE_W-1:0]    remain;
  logic [CNT_W-1:0]     step_inc;

  status_t              res_status;
  logic [SIZE_W-1:0]    res_offset;
  logic [LEN_W-1:0]     res_length;
  logic [CLUSTER_W-1:0] res_index;
  logic                 res_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_take   = s_tvalid && s_tready;

  assign cmd      = command_t'(s_tuser);
  assign in_first = s_tdata[15:0];
  assign in_size  = s_tdata[47:16];
  assign in_next  = s_tdata[63:48];

  assign clus     = (cmd == CMD_START) ? in_first : in_next;
  assign avail    = (cmd == CMD_START) ? in_size : bytes_left;
  assign step_inc = steps + 17'd1;
  assign clus_rel = clus - FIRST_DATA_CLUSTER;
  assign prod     = {16'd0, clus_rel} * {15'd0, bpc};
  assign offset   = data_base + prod;
  assign len      = (avail < {15'd0, bpc}) ? avail[LEN_W-1:0] : bpc;
  assign remain   = avail - {15'd0, len};

  always_comb begin
    res_status      = ST_READ;
    res_offset      = '0;
    res_length      = '0;
    res_index       = '0;
    res_last        = 1'b1;
    do_take         = 1'b0;
    bytes_left_next = bytes_left;
    steps_next      = steps;
    walking_next    = walking;

    case (cmd)
      CMD_START: begin
        bytes_left_next = in_size;
        steps_next      = '0;
        walking_next    = 1'b0;
        if (in_size == '0) begin
          res_status = ST_EMPTY;
        end else begin
          do_take = 1'b1;
        end
      end
      CMD_SUPPLY: begin
        if (!walking) begin
          res_status = ST_IGNORED;
          res_last   = 1'b0;
        end else begin
          steps_next = step_inc;
          if (step_inc > fat_entries) begin
            res_status   = ST_LOOP;
            walking_next = 1'b0;
          end else begin
            do_take = 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_IGNORED;
        res_last   = 1'b0;
      end
    endcase

    if (do_take) begin
      walking_next = 1'b0;
      if (clus < FIRST_DATA_CLUSTER) begin
        res_status = ST_BAD;
      end else if (clus >= eoc_mark) begin
        res_status = ST_ENDED;
      end else if ({1'b0, clus} >= fat_entries) begin
        res_status = ST_RANGE;
      end else begin
        res_status      = ST_READ;
        res_offset      = offset;
        res_length      = len;
        bytes_left_next = remain;
        if (remain != '0) begin
          walking_next = 1'b1;
          res_index    = clus;
          res_last     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base   <= RST_DATA_START;
      bpc         <= RST_BPC;
      fat_entries <= RST_FAT_ENTRIES;
      eoc_mark    <= RST_EOC_MARK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DATA_START:  data_base   <= cfg_data;
        REG_BPC:         bpc         <= cfg_data[LEN_W-1:0];
        REG_FAT_ENTRIES: fat_entries <= cfg_data[CNT_W-1:0];
        REG_EOC_MARK:    eoc_mark    <= cfg_data[CLUSTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      steps      <= '0;
      walking    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (in_take) begin
        bytes_left <= bytes_left_next;
        steps      <= steps_next;
        walking    <= walking_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_index, res_length, res_offset};
      m_tlast <= res_last;
    end
  end

  property p_walk_matches_result;
    @(posedge clk) disable iff (rst)
      in_take |=> (walking == (m_tuser == ST_READ && !m_tlast));
  endproperty
  a_walk_matches_result: assert property (p_walk_matches_result)
    else $error("walk state disagrees with issued result");

  property p_no_read_fields_on_stop;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser != ST_READ) |-> (m_tdata[48:0] == '0);
  endproperty
  a_no_read_fields_on_stop: assert property (p_no_read_fields_on_stop)
    else $error("offset or length set on a non-read result");

  property p_next_index_valid;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ST_READ && !m_tlast) |-> (m_tdata[64:49] >= FIRST_DATA_CLUSTER);
  endproperty
  a_next_index_valid: assert property (p_next_index_valid)
    else $error("continuing read without a valid next cluster");

  property p_ignored_not_last;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == ST_IGNORED) |-> (!m_tlast && m_tdata[64:49] == '0);
  endproperty
  a_ignored_not_last: assert property (p_ignored_not_last)
    else $error("ignored supply carries last or index");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT16 cluster chain reader. A queue of start and
// supply beats feeds the input stream; a predictor walks the same chain and
// queues the read request each beat should produce, and a monitor compares
// every output beat field by field. Several register settings are run,
// extremes included, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import fccr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;

  typedef struct packed {
    command_t               cmd;
    logic [CLUSTER_W-1:0]   first_cluster;
    logic [SIZE_W-1:0]      byte_count;
    logic [CLUSTER_W-1:0]   next_cluster;
  } file_item_t;

  typedef struct packed {
    status_t                status;
    logic [SIZE_W-1:0]      read_offset;
    logic [LEN_W-1:0]       read_length;
    logic [CLUSTER_W-1:0]   fat_index;
    logic                   last;
  } read_req_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [2:0]              m_tuser;
  logic                    m_tlast;

  fat16_cluster_chain_reader_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers and walk state
  logic [SIZE_W-1:0]     pr_data_start  = RST_DATA_START;
  logic [LEN_W-1:0]      pr_bpc         = RST_BPC;
  logic [CNT_W-1:0]      pr_fat_entries = RST_FAT_ENTRIES;
  logic [CLUSTER_W-1:0]  pr_eoc_mark    = RST_EOC_MARK;
  logic [SIZE_W-1:0]     pr_bytes_left  = '0;
  logic [CLUSTER_W-1:0]  pr_cluster     = '0;
  logic [CNT_W-1:0]      pr_steps       = '0;
  logic                  pr_walking     = 1'b0;

  file_item_t   file_cmds[$];
  read_req_t    expected_reads[$];
  file_item_t   cur_item;
  read_req_t    want;
  int unsigned  n_mismatch = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  in_gap = 0;
  int unsigned  in_calm = 0;
  int unsigned  out_stall = 0;
  int unsigned  out_calm = 0;

  function automatic read_req_t take_up_cluster();
    read_req_t r;
    logic [SIZE_W-1:0] len;
    r = '0;
    r.last = 1'b1;
    pr_walking = 1'b0;
    if (pr_cluster < FIRST_DATA_CLUSTER) begin
      r.status = ST_BAD;
    end else if (pr_cluster >= pr_eoc_mark) begin
      r.status = ST_ENDED;
    end else if ({1'b0, pr_cluster} >= pr_fat_entries) begin
      r.status = ST_RANGE;
    end else begin
      r.status = ST_READ;
      r.read_offset = pr_data_start + (32'(pr_cluster) - 32'd2) * 32'(pr_bpc);
      len = 32'(pr_bpc);
      if (pr_bytes_left < len) len = pr_bytes_left;
      pr_bytes_left = pr_bytes_left - len;
      r.read_length = len[LEN_W-1:0];
      if (pr_bytes_left != 0) begin
        pr_walking = 1'b1;
        r.fat_index = pr_cluster;
        r.last = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic read_req_t walk_chain(input file_item_t it);
    read_req_t r;
    r = '0;
    if (it.cmd == CMD_START) begin
      pr_bytes_left = it.byte_count;
      pr_cluster = it.first_cluster;
      pr_steps = '0;
      pr_walking = 1'b0;
      if (pr_bytes_left == 0) begin
        r.status = ST_EMPTY;
        r.last = 1'b1;
      end else begin
        r = take_up_cluster();
      end
    end else if (!pr_walking) begin
      r.status = ST_IGNORED;
    end else begin
      pr_cluster = it.next_cluster;
      pr_steps = pr_steps + 1'b1;
      if (pr_steps > pr_fat_entries) begin
        pr_walking = 1'b0;
        r.status = ST_LOOP;
        r.last = 1'b1;
      end else begin
        r = take_up_cluster();
      end
    end
    return r;
  endfunction

  task automatic next_gap(inout int unsigned calm, output int unsigned gap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r == 0) begin
      calm = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 50) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 98) begin
      gap = $urandom_range(4, 20);
    end else begin
      gap = $urandom_range(30, 100);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (s_tvalid && s_tready) expected_reads.push_back(walk_chain(cur_item));
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (file_cmds.size() > 0) begin
          cur_item = file_cmds.pop_front();
          s_tdata <= {cur_item.next_cluster, cur_item.byte_count, cur_item.first_cluster};
          s_tuser <= cur_item.cmd;
          s_tvalid <= 1'b1;
          next_gap(in_calm, in_gap);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_mismatch++;
    end
  endtask

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reads.size() == 0) begin
          $error("read request beat with none expected, status %0d", m_tuser);
          n_mismatch++;
        end else begin
          want = expected_reads.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("read_offset", want.read_offset, m_tdata[31:0]);
          check_field("read_length", 32'(want.read_length), 32'(m_tdata[48:32]));
          check_field("fat_index", 32'(want.fat_index), 32'(m_tdata[64:49]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) next_gap(out_calm, out_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_start(input logic [CLUSTER_W-1:0] fc, input logic [SIZE_W-1:0] fs);
    file_item_t it;
    it.cmd = CMD_START;
    it.first_cluster = fc;
    it.byte_count = fs;
    it.next_cluster = CLUSTER_W'($urandom);
    file_cmds.push_back(it);
  endtask

  task automatic push_supply(input logic [CLUSTER_W-1:0] nc);
    file_item_t it;
    it.cmd = CMD_SUPPLY;
    it.first_cluster = CLUSTER_W'($urandom);
    it.byte_count = $urandom;
    it.next_cluster = nc;
    file_cmds.push_back(it);
  endtask

  task automatic push_noise();
    file_item_t it;
    it.cmd = command_t'($urandom_range(0, 1));
    it.first_cluster = CLUSTER_W'($urandom);
    it.byte_count = $urandom;
    it.next_cluster = CLUSTER_W'($urandom);
    file_cmds.push_back(it);
  endtask

  function automatic logic [CLUSTER_W-1:0] good_cluster();
    int unsigned lim;
    lim = (pr_fat_entries < {1'b0, pr_eoc_mark}) ? pr_fat_entries : pr_eoc_mark;
    if (lim <= 2) return CLUSTER_W'($urandom);
    if ($urandom_range(0, 7) == 0) return CLUSTER_W'(lim - 1);
    return CLUSTER_W'($urandom_range(2, lim - 1));
  endfunction

  task automatic push_chain();
    int unsigned n;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    logic [SIZE_W-1:0] size;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    if (pr_bpc == 0) size = $urandom_range(1, 5000);
    else size = (n - 1) * pr_bpc + $urandom_range(1, pr_bpc);
    if ($urandom_range(0, 19) == 0) size = $urandom;
    if ($urandom_range(0, 29) == 0) size = '0;
    if ($urandom_range(0, 9) == 0) push_start(CLUSTER_W'($urandom), size);
    else push_start(good_cluster(), size);
    k = n - 1;
    if ($urandom_range(0, 4) == 0) k = $urandom_range(0, k);
    for (int i = 0; i < k; i++) push_supply(good_cluster());
    case ($urandom_range(0, 9))
      0: push_supply(CLUSTER_W'($urandom_range(pr_eoc_mark, 65535)));
      1: push_supply(CLUSTER_W'($urandom_range(0, 1)));
      2: begin
        lo = pr_fat_entries;
        hi = pr_eoc_mark;
        if (lo < hi) push_supply(CLUSTER_W'($urandom_range(lo, hi - 1)));
      end
      3: push_supply(CLUSTER_W'($urandom));
      default: ;
    endcase
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned target;
    target = file_cmds.size() + count;
    while (file_cmds.size() < target) begin
      if ($urandom_range(0, 9) < 8) push_chain();
      else push_noise();
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (file_cmds.size() != 0 || s_tvalid || expected_reads.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [SIZE_W-1:0] drs, input logic [LEN_W-1:0] bpc,
                              input logic [CNT_W-1:0] fat, input logic [CLUSTER_W-1:0] eoc);
    logic [CFG_W-1:0]     vals[4];
    logic [CFG_IDX_W-1:0] idxs[4];
    vals = '{drs, 32'(bpc), 32'(fat), 32'(eoc)};
    idxs = '{REG_DATA_START, REG_BPC, REG_FAT_ENTRIES, REG_EOC_MARK};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk);
      while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    pr_data_start = drs;
    pr_bpc = bpc;
    pr_fat_entries = fat;
    pr_eoc_mark = eoc;
  endtask

  task automatic program_random();
    logic [LEN_W-1:0]     bpc;
    logic [CNT_W-1:0]     fat;
    logic [CLUSTER_W-1:0] eoc;
    case ($urandom_range(0, 9))
      0: bpc = 17'd1;
      1: bpc = 17'd65536;
      2: bpc = '0;
      3, 4, 5: bpc = LEN_W'($urandom_range(1, 64));
      default: bpc = LEN_W'($urandom_range(1, 65536));
    endcase
    case ($urandom_range(0, 9))
      0: fat = 17'd65536;
      1: fat = '0;
      2, 3, 4: fat = CNT_W'($urandom_range(1, 12));
      default: fat = CNT_W'($urandom_range(2, 65536));
    endcase
    case ($urandom_range(0, 9))
      0: eoc = 16'd65535;
      1: eoc = CLUSTER_W'($urandom_range(0, 1));
      2, 3: eoc = CLUSTER_W'($urandom_range(2, 20));
      default: eoc = CLUSTER_W'($urandom_range(2, 65535));
    endcase
    program_regs($urandom, bpc, fat, eoc);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    push_supply(16'hFFFF);
    push_start(16'hFFFF, 32'd0);
    push_start(16'd0, 32'd1);
    push_start(16'd1, 32'hFFFF_FFFF);
    push_start(16'd65528, 32'd100);
    push_start(16'd65527, 32'hFFFF_FFFF);
    push_supply(16'd2);
    push_start(16'd2, 32'd512);
    push_supply(16'd5);
    push_start(16'd3, 32'd1025);
    push_supply(16'd65535);
    push_start(16'd100, 32'd1300);
    push_supply(16'd0);
    push_start(16'd2, 32'd1025);
    push_supply(16'd3);
    push_supply(16'd4);
    wait_idle();

    // zero cluster size, tiny FAT: loop bound and out of range
    program_regs(32'd1000, 17'd0, 17'd3, 16'd65535);
    push_start(16'd2, 32'd10);
    repeat (4) push_supply(16'd2);
    push_start(16'd3, 32'd5);
    push_supply(16'd9);
    wait_idle();

    // end-of-chain mark below 2
    program_regs(32'd5, 17'd7, 17'd16, 16'd1);
    push_start(16'd2, 32'd9);
    push_start(16'd1, 32'd9);
    push_start(16'd0, 32'd0);
    wait_idle();

    // widest values, offset wraps
    program_regs(32'hFFFF_FFFF, 17'd65536, 17'd65536, 16'd65535);
    push_start(16'd65534, 32'hFFFF_FFFF);
    push_supply(16'd65534);
    push_supply(16'd65535);
    push_start(16'd2, 32'd65536);
    push_random(120);
    wait_idle();

    // empty FAT
    program_regs(32'd0, 17'd1, 17'd0, 16'd65535);
    push_random(60);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      program_random();
      push_random(150);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
